FILE: rtl/gstc_pkg.sv
// Shared types and constants for the gyro self-test checker.
// Holds payload structs, stage encoding, register codes and widths.
// No dependencies.
`default_nettype none

package gstc_pkg;

  // Default number of samples summed per phase (legal range 1 to 15)
  localparam int SAMPLES_AVERAGED = 5;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 4;
  // On-minus-off running difference, sized for fifteen samples per phase
  localparam int DIFF_W   = 21;
  localparam int MAG_W    = 20;
  localparam int SCALE_W  = 8;
  localparam int LIMIT_W  = 24;
  localparam int RESP_W   = 24;
  localparam int PROD_W   = MAG_W + SCALE_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET     = 8'd70;
  localparam logic [LIMIT_W-1:0] MIN_LIMIT_RESET = 24'd150000;
  localparam logic [LIMIT_W-1:0] MAX_LIMIT_RESET = 24'd700000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFF_COLLECT,
    ST_OFF_DONE,
    ST_ON_COLLECT
  } gstc_stage_t;

  typedef struct packed {
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;
    logic       stimulus_on;
  } gstc_in_t;

  typedef struct packed {
    logic              test_passed;
    logic [RESP_W-1:0] response_x;
    logic [RESP_W-1:0] response_y;
    logic [RESP_W-1:0] response_z;
  } gstc_out_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] diff_z;
  } gstc_diff_t;

endpackage

`default_nettype wire

FILE: rtl/gstc_accum.sv
// Test sequencer and per-axis on-minus-off accumulators.
// Emits the final sum difference of a completed test into a one-entry register.
// Depends on gstc_pkg.
`default_nettype none

module gstc_accum #(
  parameter int SamplesAveraged = gstc_pkg::SAMPLES_AVERAGED
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gstc_pkg::gstc_in_t  in_data,
  output logic                     diff_valid,
  input  wire logic                diff_ready,
  output gstc_pkg::gstc_diff_t     diff_data
);
  import gstc_pkg::*;

  gstc_stage_t              stage, stage_next;
  logic [CNT_W-1:0]         count, count_next, count_inc;
  logic signed [DIFF_W-1:0] acc [3];
  logic signed [DIFF_W-1:0] acc_next [3];
  logic signed [DIFF_W-1:0] smp [3];
  logic signed [DIFF_W-1:0] acc_sum [3];
  logic                     accept, done, emit;
  logic [SAMPLE_W-1:0]      word [3];

  assign in_ready  = !diff_valid || diff_ready;
  assign accept    = in_valid && in_ready;
  assign count_inc = count + CNT_W'(1);
  assign done      = count_inc >= CNT_W'(SamplesAveraged);

  assign word[0] = {in_data.x_high_byte, in_data.x_low_byte};
  assign word[1] = {in_data.y_high_byte, in_data.y_low_byte};
  assign word[2] = {in_data.z_high_byte, in_data.z_low_byte};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      smp[j]     = {{(DIFF_W-SAMPLE_W){word[j][SAMPLE_W-1]}}, word[j]};
      acc_sum[j] = acc[j] + smp[j];
    end
  end

  // Next stage and sample count
  always_comb begin
    stage_next = stage;
    count_next = count;
    if (accept) begin
      if (!in_data.stimulus_on) begin
        if (stage != ST_OFF_COLLECT) begin
          // start a new test; this sample is discarded
          stage_next = ST_OFF_COLLECT;
          count_next = '0;
        end else if (done) begin
          stage_next = ST_OFF_DONE;
          count_next = '0;
        end else begin
          count_next = count_inc;
        end
      end else begin
        unique case (stage)
          ST_OFF_DONE: stage_next = ST_ON_COLLECT;
          ST_ON_COLLECT: begin
            if (done) begin
              stage_next = ST_IDLE;
              count_next = '0;
            end else begin
              count_next = count_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Accumulator update and result launch
  always_comb begin
    emit = 1'b0;
    for (int j = 0; j < 3; j++) acc_next[j] = acc[j];
    if (accept) begin
      if (!in_data.stimulus_on) begin
        for (int j = 0; j < 3; j++) begin
          acc_next[j] = (stage != ST_OFF_COLLECT) ? '0 : acc[j] - smp[j];
        end
      end else if (stage == ST_ON_COLLECT) begin
        emit = done;
        for (int j = 0; j < 3; j++) acc_next[j] = done ? '0 : acc_sum[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= ST_IDLE;
      count      <= '0;
      diff_valid <= 1'b0;
      for (int j = 0; j < 3; j++) acc[j] <= '0;
    end else begin
      stage <= stage_next;
      count <= count_next;
      for (int j = 0; j < 3; j++) acc[j] <= acc_next[j];
      if (emit) begin
        diff_valid <= 1'b1;
      end else if (diff_ready) begin
        diff_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      diff_data.diff_x <= acc_sum[0];
      diff_data.diff_y <= acc_sum[1];
      diff_data.diff_z <= acc_sum[2];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < CNT_W'(SamplesAveraged))
    else $error("phase sample count reached the sample total");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (stage == ST_IDLE || stage == ST_OFF_DONE) |-> count == '0)
    else $error("sample count not cleared between phases");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    emit |=> (stage == ST_IDLE) && diff_valid)
    else $error("completed test did not return to idle with a result");
`endif

endmodule

`default_nettype wire

FILE: rtl/gstc_response.sv
// Response pipeline: magnitude times scale, divide by sample count via
// reciprocal partial products, limit check, output register. Depends on gstc_pkg.
`default_nettype none

module gstc_response #(
  parameter int SamplesAveraged = gstc_pkg::SAMPLES_AVERAGED
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          diff_valid,
  output logic                               diff_ready,
  input  wire gstc_pkg::gstc_diff_t          diff_data,
  input  wire logic [gstc_pkg::SCALE_W-1:0]  scale,
  input  wire logic [gstc_pkg::LIMIT_W-1:0]  min_limit,
  input  wire logic [gstc_pkg::LIMIT_W-1:0]  max_limit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output gstc_pkg::gstc_out_t                out_data
);
  import gstc_pkg::*;

  // floor(p / N) == (p * Recip) >> DivShift exactly for p below 2**PROD_W
  localparam int DivShift = PROD_W + CNT_W;
  localparam int RECIP_W  = DivShift + 1;
  localparam logic [RECIP_W-1:0] Recip = RECIP_W'(
    ((64'd1 << DivShift) + 64'(SamplesAveraged) - 64'd1) / 64'(SamplesAveraged));
  localparam int HALF_W = PROD_W / 2;
  localparam int HI_W   = PROD_W - HALF_W;
  localparam int PP_W   = HI_W + RECIP_W;
  localparam int SUM_W  = PP_W + HALF_W + 1;

  logic                     v2, v3, v4;
  logic                     ld2, ld3, ld4, ld_out;
  logic                     adv3, adv4, out_adv;
  logic signed [DIFF_W-1:0] dif [3];
  logic [DIFF_W-1:0]        abs_d [3];
  logic [PROD_W-1:0]        prod2 [3];
  logic [PP_W-1:0]          pp_hi3 [3];
  logic [PP_W-1:0]          pp_lo3 [3];
  logic [SUM_W-1:0]         total [3];
  logic [RESP_W-1:0]        resp4 [3];
  logic [2:0]               in_lim;

  // Each stage loads when it is empty or its content moves on
  assign out_adv    = !out_valid || out_ready;
  assign adv4       = !v4 || out_adv;
  assign adv3       = !v3 || adv4;
  assign diff_ready = !v2 || adv3;
  assign ld2        = diff_valid && diff_ready;
  assign ld3        = v2 && adv3;
  assign ld4        = v3 && adv4;
  assign ld_out     = v4 && out_adv;

  assign dif[0] = diff_data.diff_x;
  assign dif[1] = diff_data.diff_y;
  assign dif[2] = diff_data.diff_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      abs_d[j] = dif[j][DIFF_W-1] ? DIFF_W'(-dif[j]) : DIFF_W'(dif[j]);
      total[j] = (SUM_W'(pp_hi3[j]) << HALF_W) + SUM_W'(pp_lo3[j]);
      in_lim[j] = (resp4[j] >= min_limit) && (resp4[j] <= max_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (diff_ready) v2 <= diff_valid;
      if (adv3)       v3 <= v2;
      if (adv4)       v4 <= v3;
      if (out_adv)    out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (ld2) begin
        prod2[j] <= PROD_W'(abs_d[j][MAG_W-1:0]) * PROD_W'(scale);
      end
      if (ld3) begin
        pp_hi3[j] <= PP_W'(prod2[j][PROD_W-1:HALF_W]) * PP_W'(Recip);
        pp_lo3[j] <= PP_W'(prod2[j][HALF_W-1:0]) * PP_W'(Recip);
      end
      if (ld4) begin
        resp4[j] <= total[j][DivShift +: RESP_W];
      end
    end
    if (ld_out) begin
      out_data.test_passed <= &in_lim;
      out_data.response_x  <= resp4[0];
      out_data.response_y  <= resp4[1];
      out_data.response_z  <= resp4[2];
    end
  end

`ifndef NO_ASSERTIONS
  a_stage2_load: assert property (@(posedge clk) disable iff (rst)
    diff_valid && diff_ready |=> v2)
    else $error("accepted difference lost at product stage");

  a_stage3_load: assert property (@(posedge clk) disable iff (rst)
    v2 && adv3 |=> v3)
    else $error("product lost at reciprocal stage");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    v4 && out_adv |=> out_valid)
    else $error("response lost at output register");
`endif

endmodule

`default_nettype wire

FILE: rtl/gyro_self_test_checker.sv
// Gyro self-test checker top level: configuration registers, sequencer and
// response pipeline. Depends on gstc_pkg, gstc_accum and gstc_response.
//
// Takes one sample per cycle while in_ready is high. The result of a test is launched
// when its last stimulus-on sample is accepted and then passes the four register
// stages of the response pipeline (product, reciprocal partial products, quotient,
// limit check). The pipeline holds up to five results; the input stalls only
// when all of them wait on out_ready. Configuration writes take effect on the
// next cycle and belong between tests.
`default_nettype none

module gyro_self_test_checker #(
  parameter int SamplesAveraged = gstc_pkg::SAMPLES_AVERAGED
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire gstc_pkg::gstc_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output gstc_pkg::gstc_out_t                   out_data,
  input  wire logic                             cfg_write,
  input  wire logic [gstc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gstc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gstc_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic [LIMIT_W-1:0] min_limit;
  logic [LIMIT_W-1:0] max_limit;
  logic               diff_valid, diff_ready;
  gstc_diff_t         diff_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RESET;
      min_limit <= MIN_LIMIT_RESET;
      max_limit <= MAX_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE:     scale     <= cfg_data[SCALE_W-1:0];
        REG_MIN_LIMIT: min_limit <= cfg_data[LIMIT_W-1:0];
        REG_MAX_LIMIT: max_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  gstc_accum #(
    .SamplesAveraged(SamplesAveraged)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff_data  (diff_data)
  );

  gstc_response #(
    .SamplesAveraged(SamplesAveraged)
  ) u_response (
    .clk        (clk),
    .rst        (rst),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff_data  (diff_data),
    .scale      (scale),
    .min_limit  (min_limit),
    .max_limit  (max_limit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: dv/tb_gyro_self_test_checker.sv
// Self-checking testbench for the gyro self-test checker.
// Depends on gstc_pkg and gyro_self_test_checker. Predicts each response at
// sample acceptance and compares it with what the block returns.
module tb_gyro_self_test_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import gstc_pkg::*;

  localparam int N_AVG         = SAMPLES_AVERAGED;
  localparam int TEST_LEN      = 2 * N_AVG + 2;
  localparam int IDLE_PCT      = 21;
  localparam int SAMPLE_TARGET = 400;
  localparam int RESULT_TARGET = 25;
  localparam int PHASE_SAMPLES = 40;
  localparam int MAX_PHASES    = 40;
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  gstc_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gstc_out_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gyro_self_test_checker #(.SamplesAveraged(N_AVG)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the block's state and registers
  gstc_stage_t              stage_q = ST_IDLE;
  logic [CNT_W-1:0]         count_q = '0;
  logic signed [DIFF_W-1:0] off_sum [3] = '{default: '0};
  logic signed [DIFF_W-1:0] on_sum [3] = '{default: '0};
  logic [SCALE_W-1:0]       scale_r = SCALE_RESET;
  logic [LIMIT_W-1:0]       min_r = MIN_LIMIT_RESET;
  logic [LIMIT_W-1:0]       max_r = MAX_LIMIT_RESET;

  gstc_in_t  samples_to_send [$];
  gstc_out_t expected_responses [$];

  logic in_fire = 1'b0;
  int   idle_pct = IDLE_PCT;
  int   samples_accepted = 0;
  int   samples_used = 0;
  int   responses_checked = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   settings_used = 1;

  task automatic clear_sums();
    count_q = '0;
    for (int j = 0; j < 3; j++) begin
      off_sum[j] = '0;
      on_sum[j] = '0;
    end
  endtask

  task automatic predict_response(input gstc_in_t s, output bit ignored);
    logic signed [SAMPLE_W-1:0] raw [3];
    logic signed [DIFF_W-1:0]   diff;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [RESP_W-1:0]          resp [3];
    gstc_out_t                  r;
    bit                         all_in;
    raw[0] = {s.x_high_byte, s.x_low_byte};
    raw[1] = {s.y_high_byte, s.y_low_byte};
    raw[2] = {s.z_high_byte, s.z_low_byte};
    ignored = 1'b0;
    if (!s.stimulus_on && stage_q != ST_OFF_COLLECT) begin
      // discard this sample and start over
      clear_sums();
      stage_q = ST_OFF_COLLECT;
    end else if (!s.stimulus_on) begin
      for (int j = 0; j < 3; j++) off_sum[j] = off_sum[j] + raw[j];
      count_q = count_q + 1'b1;
      if (count_q >= N_AVG) begin
        count_q = '0;
        stage_q = ST_OFF_DONE;
      end
    end else if (stage_q == ST_OFF_DONE) begin
      stage_q = ST_ON_COLLECT;
    end else if (stage_q != ST_ON_COLLECT) begin
      ignored = 1'b1;
    end else begin
      for (int j = 0; j < 3; j++) on_sum[j] = on_sum[j] + raw[j];
      count_q = count_q + 1'b1;
      if (count_q >= N_AVG) begin
        all_in = 1'b1;
        for (int j = 0; j < 3; j++) begin
          diff = on_sum[j] - off_sum[j];
          mag = MAG_W'((diff < 0) ? -diff : diff);
          prod = PROD_W'(mag) * PROD_W'(scale_r);
          resp[j] = RESP_W'(prod / N_AVG);
          if (resp[j] < min_r || resp[j] > max_r) all_in = 1'b0;
        end
        r.test_passed = all_in;
        r.response_x = resp[0];
        r.response_y = resp[1];
        r.response_z = resp[2];
        expected_responses.push_back(r);
        stage_q = ST_IDLE;
        clear_sums();
      end
    end
  endtask

  function automatic gstc_in_t make_sample(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z, input logic on);
    gstc_in_t s;
    s.x_low_byte = x[7:0];
    s.x_high_byte = x[15:8];
    s.y_low_byte = y[7:0];
    s.y_high_byte = y[15:8];
    s.z_low_byte = z[7:0];
    s.z_high_byte = z[15:8];
    s.stimulus_on = on;
    return s;
  endfunction

  // Queue the first upto samples of one off/on test. A realistic test keeps
  // each axis near a base rate and shifts it by a fixed step when stimulus is on.
  task automatic queue_test(input bit realistic, input int upto);
    int          base [3];
    int          step [3];
    logic [15:0] v [3];
    logic        on;
    for (int j = 0; j < 3; j++) begin
      base[j] = int'($urandom_range(0, 4000)) - 2000;
      step[j] = int'($urandom_range(1000, 12000));
      if ($urandom_range(1) != 0) step[j] = -step[j];
    end
    for (int k = 0; k < TEST_LEN && k < upto; k++) begin
      on = (k > N_AVG);
      for (int j = 0; j < 3; j++) begin
        if (realistic) begin
          v[j] = 16'(base[j] + (on ? step[j] : 0) + int'($urandom_range(0, 100)) - 50);
        end else begin
          v[j] = 16'($urandom);
        end
      end
      samples_to_send.push_back(make_sample(v[0], v[1], v[2], on));
    end
  endtask

  task automatic wait_drained();
    while (samples_to_send.size() != 0 || in_valid || expected_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Feed samples until the block is back in idle with nothing in flight
  task automatic finish_test();
    wait_drained();
    while (stage_q != ST_IDLE) begin
      if (stage_q == ST_OFF_COLLECT) begin
        samples_to_send.push_back(make_sample(16'($urandom), 16'($urandom),
                                              16'($urandom), 1'b0));
      end else begin
        queue_test(1'b1, TEST_LEN);
      end
      wait_drained();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SCALE:     scale_r = value[SCALE_W-1:0];
      REG_MIN_LIMIT: min_r = value[LIMIT_W-1:0];
      REG_MAX_LIMIT: max_r = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int scale, input int lo, input int hi);
    write_reg(REG_SCALE, CFG_DATA_W'(scale));
    write_reg(REG_MIN_LIMIT, CFG_DATA_W'(lo));
    write_reg(REG_MAX_LIMIT, CFG_DATA_W'(hi));
    settings_used++;
  endtask

  // Driver: hold an item until it is taken, then maybe advance
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= samples_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Monitor: check returned responses, predict from accepted samples
  always @(posedge clk) begin
    bit        ignored;
    gstc_out_t want;
    in_fire <= in_valid && in_ready;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_responses.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) begin
        responses_checked++;
        if (expected_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected response: pass=%0b x=%0d y=%0d z=%0d",
                     out_data.test_passed, out_data.response_x,
                     out_data.response_y, out_data.response_z);
          end
        end else begin
          want = expected_responses.pop_front();
          if (out_data.test_passed !== want.test_passed ||
              out_data.response_x !== want.response_x ||
              out_data.response_y !== want.response_y ||
              out_data.response_z !== want.response_z) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Response %0d expected: pass=%0b x=%0d y=%0d z=%0d",
                       responses_checked, want.test_passed, want.response_x,
                       want.response_y, want.response_z);
              $display("Response %0d actual:   pass=%0b x=%0d y=%0d z=%0d",
                       responses_checked, out_data.test_passed,
                       out_data.response_x, out_data.response_y, out_data.response_z);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        samples_accepted++;
        predict_response(in_data, ignored);
        if (!ignored) samples_used++;
      end
    end
  end

  initial begin
    int pick;
    int queued;
    int len;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: ignored stimulus-on, restart from off-done, extreme words
    samples_to_send.push_back(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    samples_to_send.push_back(make_sample(16'h7F7F, 16'h0080, 16'hFF00, 1'b0));
    repeat (2) samples_to_send.push_back(make_sample(16'h8000, 16'h00FF, 16'hFF00, 1'b0));
    samples_to_send.push_back(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
    repeat (3) samples_to_send.push_back(make_sample(16'h8000, 16'h00FF, 16'hFF00, 1'b0));
    samples_to_send.push_back(make_sample(16'h1234, 16'h5678, 16'h9ABC, 1'b0));
    repeat (N_AVG) samples_to_send.push_back(make_sample(16'h8000, 16'h0000, 16'h7FFF, 1'b0));
    samples_to_send.push_back(make_sample(16'h0000, 16'h0000, 16'h0000, 1'b1));
    repeat (N_AVG) samples_to_send.push_back(make_sample(16'h7FFF, 16'h0000, 16'h8000, 1'b1));
    finish_test();

    for (int phase = 1; phase <= MAX_PHASES &&
         (samples_used < SAMPLE_TARGET || responses_checked < RESULT_TARGET); phase++) begin
      case (phase)
        1: set_limits(255, 0, 24'hFFFFFF);
        2: set_limits(0, 0, 0);
        3: set_limits(0, 1, 24'hFFFFFF);
        4: set_limits(70, 700000, 150000);
        5: set_limits(1, 0, 1000);
        6: set_limits(70, 150000, 700000);
        default: begin
          len = $urandom_range(0, 500000);
          set_limits($urandom_range(1, 255), len, len + $urandom_range(0, 4000000));
        end
      endcase
      idle_pct = (phase == 6) ? 0 : IDLE_PCT;
      queued = 0;
      while (queued < PHASE_SAMPLES) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          queue_test(1'($urandom_range(1)), TEST_LEN);
          queued += TEST_LEN;
        end else if (pick < 85) begin
          // cut a test short so the next one restarts it
          len = $urandom_range(1, TEST_LEN - 1);
          queue_test(1'($urandom_range(1)), len);
          queued += len;
        end else begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            samples_to_send.push_back(make_sample(16'($urandom), 16'($urandom),
                                                  16'($urandom), 1'($urandom_range(1))));
          end
          queued += len;
        end
      end
      finish_test();
    end

    $display("Run covered %0d samples (%0d acted on) over %0d register settings",
             samples_accepted, samples_used, settings_used);
    $display("%0d responses checked, %0d mismatches", responses_checked, mismatches);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
